FILE: sv/kerf_pkg.sv
// ----------------------------------------------------------------------------
// kerf_pkg
// Shared types, constants and the scancode translation table of the key
// event repeat filter.
// ----------------------------------------------------------------------------
package kerf_pkg;

    localparam int NUM_KEYS   = 256;
    localparam int BLOCK_BITS = 32;
    localparam int NUM_BLOCKS = NUM_KEYS / BLOCK_BITS;
    localparam int BLK_W      = 3;
    localparam int BIT_W      = $clog2(BLOCK_BITS);
    localparam int CNT_W      = BIT_W + 1;
    localparam int SC_W       = 8;
    localparam int VC_W       = 8;
    localparam int TICK_W     = 32;
    localparam int MSG_W      = 32;
    localparam int IVAL_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MASK_W     = 64;
    localparam int NUM_MASKS  = 4;

    localparam logic [IVAL_W-1:0] MIN_REPEAT_RESET = 16'd500;
    localparam logic [SC_W-1:0]   EXT_LIMIT        = 8'h7F;
    localparam logic [15:0]       REPEAT_ONE       = 16'd1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_REPEAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXCL_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXCL_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXCL_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXCL_3     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic              is_key_down;
        logic [VC_W-1:0]   virtual_code;
        logic [MSG_W-1:0]  message_word;
    } t_event;

    typedef struct packed {
        logic push;
        logic flush;
    } t_obuf_ctl;

    localparam logic [VC_W-1:0] VK_TABLE [NUM_KEYS] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
        8'hBD, 8'hBB,
        8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50,
        8'hDB, 8'hDD, 8'h0D,
        8'hA2, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hBA, 8'hDE,
        8'hC0, 8'hA0, 8'hDC,
        8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'hBC, 8'hBE, 8'hBF, 8'hA1, 8'h6A,
        8'hA4, 8'h20, 8'h14,
        8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h13, 8'h91,
        8'h24, 8'h26, 8'h21,
        8'h6D, 8'h25, 8'h0C, 8'h27, 8'h6B, 8'h23, 8'h28, 8'h22, 8'h2D, 8'h2E, 8'h2C, 8'h00,
        8'hE2, 8'h7A, 8'h7B,
        8'h0C, 8'hEE, 8'hF1, 8'hEA, 8'hF9, 8'hF5, 8'hF3, 8'h00, 8'h00, 8'hFB, 8'h2F, 8'h7C,
        8'h7D, 8'h7E, 8'h7F,
        8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'hED, 8'h00, 8'hE9, 8'h00, 8'hC1,
        8'h00, 8'h00, 8'h87,
        8'h00, 8'h00, 8'h00, 8'h00, 8'hEB, 8'h09, 8'h00, 8'hC2, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hB1, 8'h00,
        8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'hB0, 8'h00, 8'h00, 8'h0D, 8'hA3, 8'h00, 8'h00, 8'hAD,
        8'hB6, 8'hB3, 8'h00,
        8'hB2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAE, 8'h00,
        8'hAF, 8'h00, 8'hB7,
        8'h00, 8'h00, 8'hBF, 8'h00, 8'h2A, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h90, 8'h00, 8'h24, 8'h26, 8'h21, 8'h00, 8'h25, 8'h00, 8'h27,
        8'h00, 8'h23, 8'h28,
        8'h22, 8'h2D, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5B, 8'h5C,
        8'h5D, 8'h00, 8'h5F,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, 8'hAB, 8'hA8, 8'hA9, 8'hA7, 8'hA6, 8'hAC,
        8'hB4, 8'hB5, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00,
        8'h00, 8'h00
    };

endpackage

FILE: sv/kerf_ram.sv
// ----------------------------------------------------------------------------
// kerf_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kerf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/kerf_cfg.sv
// ----------------------------------------------------------------------------
// kerf_cfg
// Configuration registers: minimum repeat interval and the 256-bit virtual
// code exclusion mask, with the exclusion lookup.
// ----------------------------------------------------------------------------
module kerf_cfg
    import kerf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_addr,
    input  logic [CFG_DATA_W-1:0] i_wdata,
    input  logic [VC_W-1:0]       i_vc,
    output logic [IVAL_W-1:0]     o_min_repeat,
    output logic                  o_excluded
);

    logic [IVAL_W-1:0] r_min_repeat;
    logic [MASK_W-1:0] r_mask [NUM_MASKS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_repeat <= MIN_REPEAT_RESET;
            for (int i = 0; i < NUM_MASKS; i++) begin
                r_mask[i] <= '0;
            end
        end else if (i_we) begin
            case (i_addr)
                REG_MIN_REPEAT: r_min_repeat <= i_wdata[IVAL_W-1:0];
                REG_EXCL_0:     r_mask[0]    <= i_wdata[MASK_W-1:0];
                REG_EXCL_1:     r_mask[1]    <= i_wdata[MASK_W-1:0];
                REG_EXCL_2:     r_mask[2]    <= i_wdata[MASK_W-1:0];
                REG_EXCL_3:     r_mask[3]    <= i_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_min_repeat = r_min_repeat;
    assign o_excluded   = r_mask[i_vc[7:6]][i_vc[5:0]];

endmodule

FILE: sv/kerf_out.sv
// ----------------------------------------------------------------------------
// kerf_out
// Result buffer: a pending slot holds the newest event until it is known
// whether it closes the run, then an output register drives the channel.
// ----------------------------------------------------------------------------
module kerf_out
    import kerf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_obuf_ctl         i_ctl,
    input  t_event            i_ev,
    output logic              o_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_is_key_down,
    output logic [VC_W-1:0]   o_virtual_code,
    output logic [MSG_W-1:0]  o_message_word,
    output logic              o_last_of_run
);

    logic   r_pend_valid;
    t_event r_pend;
    logic   r_out_valid;
    t_event r_out;
    logic   r_out_last;
    logic   out_free;
    logic   move;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_ready  = !r_pend_valid || out_free;
    assign move     = r_pend_valid && out_free && (i_ctl.push || i_ctl.flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.push && o_ready) begin
                r_pend_valid <= 1'b1;
            end else if (i_ctl.flush && o_ready) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out      <= r_pend;
            r_out_last <= i_ctl.flush;
        end
        if (i_ctl.push && o_ready) begin
            r_pend <= i_ev;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_key_down  = r_out.is_key_down;
    assign o_virtual_code = r_out.virtual_code;
    assign o_message_word = r_out.message_word;
    assign o_last_of_run  = r_out_last;

endmodule

FILE: sv/key_event_repeat_filter_top.sv
// ----------------------------------------------------------------------------
// key_event_repeat_filter_top
// Turns 32-key blocks of a keyboard snapshot into filtered key events.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one block: its index, the 32
// pressed bits and the millisecond tick. Output channel (o_out_valid /
// i_out_ready) gives zero to 32 events per block in ascending key order;
// o_last_of_run marks the final one. A block with no event gives nothing.
// The block walks the 32 keys one per cycle, unless the output stalls,
// through the 256-entry press tick RAM (read a key's tick, then check and
// write it back in the next cycle); a block stays busy from acceptance
// until its walk and final flush are done. An event waits until the next
// one or the end of the walk. One block is processed at a time; o_in_ready
// is high only when idle. A stalled receiver holds the walk once the
// pending and output slots are full. Reset clears previous key state, sets
// the repeat interval to 500 and the exclusion mask to zero. The tick RAM
// needs no clearing: a held key always has a written tick. Configuration must
// be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module key_event_repeat_filter_top
    import kerf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BLK_W-1:0]      i_block_index,
    input  logic [BLOCK_BITS-1:0] i_key_bits,
    input  logic [TICK_W-1:0]     i_now_ticks,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_is_key_down,
    output logic [VC_W-1:0]       o_virtual_code,
    output logic [MSG_W-1:0]      o_message_word,
    output logic                  o_last_of_run,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_state                r_state, n_state;
    logic [BLK_W-1:0]      r_blk;
    logic [BLOCK_BITS-1:0] r_cur;
    logic [BLOCK_BITS-1:0] r_old;
    logic [TICK_W-1:0]     r_now;
    logic [CNT_W-1:0]      r_a_bit;
    logic                  r_b_valid;
    logic [BIT_W-1:0]      r_b_bit;
    logic                  r_b_fresh;
    logic [TICK_W-1:0]     r_b_tick;
    logic [BLOCK_BITS-1:0] r_prev [NUM_BLOCKS];

    logic                  accept;
    logic                  blk_ok;
    logic [TICK_W-1:0]     ram_rdata;
    logic [TICK_W-1:0]     b_tick;
    logic [TICK_W-1:0]     diff;
    logic                  cd, pd;
    logic [SC_W-1:0]       sc;
    logic [VC_W-1:0]       vc;
    logic [IVAL_W-1:0]     min_repeat;
    logic                  excluded;
    logic                  suppress;
    logic                  active;
    logic                  ev_due;
    logic                  obuf_ready;
    logic                  stall;
    logic                  advance;
    logic                  more_bits;
    t_event                ev;
    t_obuf_ctl             obuf_ctl;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign blk_ok     = {1'b0, i_block_index} < (BLK_W + 1)'(NUM_BLOCKS);

    // key evaluation
    assign b_tick   = r_b_fresh ? ram_rdata : r_b_tick;
    assign cd       = r_cur[r_b_bit];
    assign pd       = r_old[r_b_bit];
    assign sc       = {r_blk, r_b_bit};
    assign vc       = VK_TABLE[sc];
    assign diff     = r_now - b_tick;
    assign suppress = cd && pd && (diff < {{(TICK_W-IVAL_W){1'b0}}, min_repeat});
    assign active   = r_b_valid && (cd || pd) && !suppress;
    assign ev_due   = active && !excluded;
    assign stall    = ev_due && !obuf_ready;
    assign advance  = (r_state == ST_RUN) && !stall;
    assign more_bits = r_a_bit < CNT_W'(BLOCK_BITS);

    assign ev.is_key_down  = cd;
    assign ev.virtual_code = vc;
    assign ev.message_word = {!cd, pd, 5'b0, (sc > EXT_LIMIT), sc, REPEAT_ONE};

    assign obuf_ctl.push  = ev_due && obuf_ready;
    assign obuf_ctl.flush = (r_state == ST_FLUSH);

    kerf_ram #(
        .WIDTH (TICK_W),
        .DEPTH (NUM_KEYS)
    ) u_tick_ram (
        .i_clk   (i_clk),
        .i_we    (active && !stall),
        .i_waddr (sc),
        .i_wdata (pd ? '0 : r_now),
        .i_raddr ({r_blk, r_a_bit[BIT_W-1:0]}),
        .o_rdata (ram_rdata)
    );

    kerf_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_we         (i_cfg_we),
        .i_addr       (i_cfg_addr),
        .i_wdata      (i_cfg_wdata),
        .i_vc         (vc),
        .o_min_repeat (min_repeat),
        .o_excluded   (excluded)
    );

    kerf_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (obuf_ctl),
        .i_ev           (ev),
        .o_ready        (obuf_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_is_key_down  (o_is_key_down),
        .o_virtual_code (o_virtual_code),
        .o_message_word (o_message_word),
        .o_last_of_run  (o_last_of_run)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && blk_ok) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (advance && !more_bits) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (obuf_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                r_prev[i] <= '0;
            end
        end else if (accept && blk_ok) begin
            r_b_valid <= 1'b0;
            r_prev[i_block_index] <= i_key_bits;
        end else if (advance) begin
            r_b_valid <= more_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_blk   <= i_block_index;
            r_cur   <= i_key_bits;
            r_old   <= r_prev[i_block_index];
            r_now   <= i_now_ticks;
            r_a_bit <= '0;
        end else if (advance) begin
            if (more_bits) begin
                r_b_bit   <= r_a_bit[BIT_W-1:0];
                r_b_fresh <= 1'b1;
                r_a_bit   <= r_a_bit + 1'b1;
            end
        end else begin
            r_b_fresh <= 1'b0;
            r_b_tick  <= b_tick;
        end
    end

endmodule
